// ===== hw/rtl/pfx_pkg.sv =====
// Shared types and constants for the postfix expression evaluator.
// Depends on nothing; used by the front end, the back end and the top level.
package pfx_pkg;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_MOD   = 8'h25;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MOD
    } op_t;

    // Decoded command passed from the front end to the back end.
    typedef struct packed {
        op_t        op;
        logic [3:0] digit;
        logic       last;
    } cmd_t;

endpackage

// ===== hw/rtl/pfx_front.sv =====
// Front end: accepts characters, classifies them and holds them in a short queue.
// Depends on pfx_pkg.
module pfx_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    char_code,
    input  logic          end_of_expr,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output pfx_pkg::cmd_t cmd
);

    localparam int QD = 4;

    pfx_pkg::cmd_t  q_reg [QD];
    logic [1:0]     wp_reg;
    logic [1:0]     rp_reg;
    logic [2:0]     cnt_reg;
    pfx_pkg::cmd_t  dec;
    logic           push;
    logic           pop;

    always_comb
    begin
        dec.digit = char_code[3:0];
        dec.last  = end_of_expr;
        if (char_code >= pfx_pkg::CH_ZERO && char_code <= pfx_pkg::CH_NINE)
            dec.op = pfx_pkg::OP_PUSH;
        else
        begin
            case (char_code)
                pfx_pkg::CH_PLUS:  dec.op = pfx_pkg::OP_ADD;
                pfx_pkg::CH_MINUS: dec.op = pfx_pkg::OP_SUB;
                pfx_pkg::CH_MUL:   dec.op = pfx_pkg::OP_MUL;
                pfx_pkg::CH_DIV:   dec.op = pfx_pkg::OP_DIV;
                pfx_pkg::CH_MOD:   dec.op = pfx_pkg::OP_MOD;
                default:           dec.op = pfx_pkg::OP_NONE;
            endcase
        end
    end

    assign in_ready  = (cnt_reg != 3'(QD));
    assign cmd_valid = (cnt_reg != 3'd0);
    assign cmd       = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 2'd1;
            if (pop)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end

endmodule

// ===== hw/rtl/pfx_back.sv =====
// Back end: operand stack, arithmetic with an iterative divider, result register.
// Depends on pfx_pkg.
module pfx_back #(
    parameter int STACK_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  pfx_pkg::cmd_t      cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        result_value,
    output logic [2:0]         flags
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_DIVFIN, S_PUSH, S_FIN, S_FINRD, S_OUT
    } state_t;

    state_t         state_reg;
    logic [31:0]    mem [STACK_DEPTH];
    logic [31:0]    rd_reg;
    logic [CW-1:0]  cnt_reg;
    logic [2:0]     flag_reg;
    pfx_pkg::cmd_t  cmd_reg;
    logic [31:0]    rhs_reg;
    logic [31:0]    lhs_reg;
    logic           rhs_ok_reg;
    logic           lhs_ok_reg;
    logic [31:0]    res_reg;
    logic [31:0]    q_reg;
    logic [31:0]    r_reg;
    logic [31:0]    d_reg;
    logic [5:0]     it_reg;
    logic           na_reg;
    logic           nb_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [31:0]    mem_wd;
    logic [AW-1:0]  mem_ra;
    logic [32:0]    r_sh;
    logic [32:0]    r_sub;
    logic [31:0]    out_reg;
    logic [2:0]     oflag_reg;
    logic           ov_reg;

    assign cmd_ready    = (state_reg == S_IDLE);
    assign out_valid    = ov_reg;
    assign result_value = out_reg;
    assign flags        = oflag_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_reg <= mem[mem_ra];
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = cnt_reg[AW-1:0];
        mem_wd = res_reg;
        mem_ra = cnt_reg[AW-1:0] - AW'(1);
        if (state_reg == S_IDLE && cmd_valid && cmd.op == pfx_pkg::OP_PUSH
            && cnt_reg < CW'(STACK_DEPTH))
        begin
            mem_we = 1'b1;
            mem_wd = {28'd0, cmd.digit};
        end
        else if (state_reg == S_PUSH && cnt_reg < CW'(STACK_DEPTH))
            mem_we = 1'b1;
    end

    assign r_sh  = {r_reg, q_reg[31]};
    assign r_sub = r_sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            flag_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            // A waiting result leaves unless a new one replaces it in S_OUT.
            if (ov_reg && out_ready && state_reg != S_OUT)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg <= cmd;
                        case (cmd.op)
                            pfx_pkg::OP_PUSH:
                            begin
                                if (cnt_reg < CW'(STACK_DEPTH))
                                    cnt_reg <= cnt_reg + CW'(1);
                                else
                                    flag_reg[1] <= 1'b1;
                                state_reg <= cmd.last ? S_FIN : S_IDLE;
                            end
                            pfx_pkg::OP_NONE:
                                state_reg <= cmd.last ? S_FIN : S_IDLE;
                            default:
                            begin
                                rhs_ok_reg <= (cnt_reg != '0);
                                if (cnt_reg != '0)
                                    cnt_reg <= cnt_reg - CW'(1);
                                else
                                    flag_reg[0] <= 1'b1;
                                state_reg <= S_RD1;
                            end
                        endcase
                    end
                end
                S_RD1:
                begin
                    // The read issued in S_IDLE returns the right operand now.
                    rhs_reg    <= rhs_ok_reg ? rd_reg : 32'd0;
                    lhs_ok_reg <= (cnt_reg != '0);
                    if (cnt_reg != '0)
                        cnt_reg <= cnt_reg - CW'(1);
                    else
                        flag_reg[0] <= 1'b1;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    lhs_reg   <= lhs_ok_reg ? rd_reg : 32'd0;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    case (cmd_reg.op)
                        pfx_pkg::OP_ADD:
                        begin
                            res_reg   <= lhs_reg + rhs_reg;
                            state_reg <= S_PUSH;
                        end
                        pfx_pkg::OP_SUB:
                        begin
                            res_reg   <= lhs_reg - rhs_reg;
                            state_reg <= S_PUSH;
                        end
                        pfx_pkg::OP_MUL:
                        begin
                            res_reg   <= 32'(lhs_reg * rhs_reg);
                            state_reg <= S_PUSH;
                        end
                        default:
                        begin
                            if (rhs_reg == 32'd0)
                            begin
                                flag_reg[2] <= 1'b1;
                                res_reg     <= 32'd0;
                                state_reg   <= S_PUSH;
                            end
                            else
                            begin
                                na_reg <= lhs_reg[31];
                                nb_reg <= rhs_reg[31];
                                q_reg  <= lhs_reg[31] ? 32'd0 - lhs_reg : lhs_reg;
                                d_reg  <= rhs_reg[31] ? 32'd0 - rhs_reg : rhs_reg;
                                r_reg  <= '0;
                                it_reg <= '0;
                                state_reg <= S_DIV;
                            end
                        end
                    endcase
                end
                S_DIV:
                begin
                    // One restoring step per cycle, quotient bits shift into q_reg.
                    if (!r_sub[32])
                    begin
                        r_reg <= r_sub[31:0];
                        q_reg <= {q_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= r_sh[31:0];
                        q_reg <= {q_reg[30:0], 1'b0};
                    end
                    it_reg <= it_reg + 6'd1;
                    if (it_reg == 6'd31)
                        state_reg <= S_DIVFIN;
                end
                S_DIVFIN:
                begin
                    if (cmd_reg.op == pfx_pkg::OP_MOD)
                        res_reg <= na_reg ? 32'd0 - r_reg : r_reg;
                    else
                        res_reg <= (na_reg != nb_reg) ? 32'd0 - q_reg : q_reg;
                    state_reg <= S_PUSH;
                end
                S_PUSH:
                begin
                    if (cnt_reg < CW'(STACK_DEPTH))
                        cnt_reg <= cnt_reg + CW'(1);
                    else
                        flag_reg[1] <= 1'b1;
                    state_reg <= cmd_reg.last ? S_FIN : S_IDLE;
                end
                S_FIN:
                begin
                    rhs_ok_reg <= (cnt_reg != '0);
                    if (cnt_reg == '0)
                        flag_reg[0] <= 1'b1;
                    state_reg <= S_FINRD;
                end
                S_FINRD:
                    state_reg <= S_OUT;
                S_OUT:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        out_reg   <= rhs_ok_reg ? rd_reg : 32'd0;
                        oflag_reg <= flag_reg;
                        ov_reg    <= 1'b1;
                        cnt_reg   <= '0;
                        flag_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/postfix_expression_evaluator_unit.sv =====
// Top level of the postfix expression evaluator.
// Depends on pfx_pkg, pfx_front and pfx_back.
//
// The slave channel carries one ASCII character per transfer: s_tdata holds
// the character and s_tlast marks the last character of an expression.
// Digits push their value, the operators + - * / % pop two operands and push
// the wrapped 32-bit result, and every other character is ignored.
// On the last character the top of the stack is popped and one transfer is
// sent on the master channel: m_tdata holds the signed result and m_tuser
// holds the sticky underflow, overflow and divide-by-zero flags.
// The front end takes characters into a four-entry queue, so the sender
// sees ready unless the queue is full. A digit or ignored character is taken
// in S_IDLE; + - * pass S_RD1, S_RD2, S_EXEC and S_PUSH, and / and % add the
// 32-step iterative divider in S_DIV and S_DIVFIN. The last character leads
// via S_FIN and S_FINRD to S_OUT. Reset empties the queue and the stack and
// clears the flags; stack contents are not cleared. When the receiver
// stalls, the result is held in the output register and the back end waits
// only if a second result is ready; the queue keeps taking characters.
module postfix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_value
    output logic [2:0]  m_tuser    // [0] underflow_seen, [1] overflow_seen, [2] divide_by_zero_seen
);

    logic          cmd_valid;
    logic          cmd_ready;
    pfx_pkg::cmd_t cmd;

    pfx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .char_code   (s_tdata),
        .end_of_expr (s_tlast),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd)
    );

    pfx_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .result_value (m_tdata),
        .flags        (m_tuser)
    );

endmodule

// ===== hw/rtl/pfx_checker.sv =====
// Port-level checks for the postfix expression evaluator, bound to the top level.
// Depends on postfix_expression_evaluator_unit.
module pfx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !$isunknown({m_tdata, m_tuser}))
        else $error("result carries unknown bits");

    a_ready_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> s_tready)
        else $error("input not ready after reset");

    a_no_valid_in_reset: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    a_handshake_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_tvalid, s_tready, m_tvalid, m_tready}))
        else $error("handshake signal unknown");

endmodule

bind postfix_expression_evaluator_unit pfx_checker u_pfx_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/postfix_expression_evaluator_unit_test.sv =====
// Self-checking testbench for postfix_expression_evaluator_unit.
// Depends on pfx_pkg and the evaluator RTL; drives characters, predicts and checks results.
module postfix_expression_evaluator_unit_test;

    localparam int DEPTH = 256;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  flags;    // [0] underflow, [1] overflow, [2] divide by zero
    } outcome_t;

    // One row of the directed table: a character, its end mark, and an optional
    // typed-in expected outcome that is compared against the predictor's.
    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       known;
        outcome_t   want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    postfix_expression_evaluator_unit #(.STACK_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Shadow of the operand stack and sticky flags.
    logic [31:0] shadow_stack [DEPTH];
    int          shadow_count;
    logic [2:0]  shadow_flags;
    outcome_t    pending_results [$];
    int          error_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic void shadow_push(input logic [31:0] v);
        if (shadow_count >= DEPTH)
        begin
            shadow_flags[1] = 1'b1;
        end
        else
        begin
            shadow_stack[shadow_count] = v;
            shadow_count++;
        end
    endfunction

    function automatic logic [31:0] shadow_pop();
        if (shadow_count == 0)
        begin
            shadow_flags[0] = 1'b1;
            return 32'd0;
        end
        shadow_count--;
        return shadow_stack[shadow_count];
    endfunction

    // Applies one character to the shadow state; returns 1 with the outcome
    // when the character ends the expression.
    function automatic logic evaluate_char(input logic [7:0] ch, input logic last,
                                           output outcome_t res);
        logic signed [31:0] lhs;
        logic signed [31:0] rhs;
        logic [31:0]        val;
        res = '0;
        if (ch >= pfx_pkg::CH_ZERO && ch <= pfx_pkg::CH_NINE)
        begin
            shadow_push({24'd0, ch - pfx_pkg::CH_ZERO});
        end
        else if (ch == pfx_pkg::CH_PLUS || ch == pfx_pkg::CH_MINUS || ch == pfx_pkg::CH_MUL
                 || ch == pfx_pkg::CH_DIV || ch == pfx_pkg::CH_MOD)
        begin
            rhs = shadow_pop();
            lhs = shadow_pop();
            if (ch == pfx_pkg::CH_PLUS) val = lhs + rhs;
            else if (ch == pfx_pkg::CH_MINUS) val = lhs - rhs;
            else if (ch == pfx_pkg::CH_MUL) val = lhs * rhs;
            else if (rhs == 0)
            begin
                shadow_flags[2] = 1'b1;
                val = 32'd0;
            end
            // The most negative value over -1 wraps; the operators would trap.
            else if (rhs == -1) val = (ch == pfx_pkg::CH_DIV) ? 32'd0 - lhs : 32'd0;
            else if (ch == pfx_pkg::CH_DIV) val = lhs / rhs;
            else val = lhs % rhs;
            shadow_push(val);
        end
        if (!last) return 1'b0;
        res.value = shadow_pop();
        res.flags = shadow_flags;
        shadow_count = 0;
        shadow_flags = '0;
        return 1'b1;
    endfunction

    // Drives one character and waits for its transfer; the prediction is
    // queued at the accepting edge so that it is there before the result.
    // Valid stays high after the transfer so that characters can follow
    // back to back; it drops only when a gap is chosen.
    task automatic send_char(input logic [7:0] ch, input logic last,
                             input logic known, input outcome_t want);
        outcome_t res;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (evaluate_char(ch, last, res))
        begin
            if (known && res.value != want.value)
                report_mismatch("table row value", res.value, want.value);
            if (known && res.flags != want.flags)
                report_mismatch("table row flags", {29'd0, res.flags}, {29'd0, want.flags});
            pending_results.push_back(res);
        end
        @(negedge clk);
    endtask

    task automatic send_expression(input string text);
        for (int i = 0; i < text.len(); i++)
            send_char(text[i], i == text.len() - 1, 1'b0, '0);
    endtask

    // An expression of 1 to 14 characters with mostly valid tokens.
    task automatic send_random_expression(output int sent);
        int depth;
        int len;
        logic [7:0] ops [5];
        logic [7:0] ch;
        ops = '{pfx_pkg::CH_PLUS, pfx_pkg::CH_MINUS, pfx_pkg::CH_MUL, pfx_pkg::CH_DIV,
                pfx_pkg::CH_MOD};
        depth = 0;
        len = $urandom_range(1, 14);
        sent = 0;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0) ch = 8'($urandom_range(0, 255));
            else if (depth >= 2 && $urandom_range(0, 1) == 1)
            begin
                ch = ops[3'($urandom_range(0, 4))];
                depth--;
            end
            else
            begin
                ch = pfx_pkg::CH_ZERO + 8'($urandom_range(0, 9));
                depth++;
            end
            send_char(ch, i == len - 1, 1'b0, '0);
            sent++;
        end
    endtask

    // The receiver stalls at random, mostly briefly.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat (($urandom_range(0, 14) == 0) ? $urandom_range(10, 80)
                        : $urandom_range(1, 3)) @(negedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(0, 8)) @(negedge clk);
        end
    end

    // Results are compared against the oldest prediction at the accepting edge.
    always @(posedge clk)
    begin
        outcome_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", m_tdata, 32'd0);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_tdata !== exp_res.value)
                    report_mismatch("result_value", m_tdata, exp_res.value);
                if (m_tuser[0] !== exp_res.flags[0])
                    report_mismatch("underflow_seen", 32'(m_tuser[0]), 32'(exp_res.flags[0]));
                if (m_tuser[1] !== exp_res.flags[1])
                    report_mismatch("overflow_seen", 32'(m_tuser[1]), 32'(exp_res.flags[1]));
                if (m_tuser[2] !== exp_res.flags[2])
                    report_mismatch("divide_by_zero_seen", 32'(m_tuser[2]),
                                    32'(exp_res.flags[2]));
            end
        end
    end

    // Run limit: far above the slowest correct run of about 1150 items plus the long
    // gaps and stalls.
    initial
    begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        row_t table_rows [$];
        int sent;
        int total;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        rst_n    = 1'b0;
        error_count = 0;
        shadow_count = 0;
        shadow_flags = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: empty end item, every operator, error cases and ignored characters.
        table_rows = '{
            '{8'h00, 1'b1, 1'b1, '{32'd0, 3'b001}},
            '{pfx_pkg::CH_NINE, 1'b1, 1'b1, '{32'd9, 3'b000}},
            '{pfx_pkg::CH_ZERO, 1'b0, 1'b0, '0}, '{8'hFF, 1'b1, 1'b1, '{32'd0, 3'b000}},
            '{pfx_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, '0}, '{pfx_pkg::CH_NINE, 1'b0, 1'b0, '0},
            '{pfx_pkg::CH_PLUS, 1'b1, 1'b1, '{32'd16, 3'b000}},
            '{pfx_pkg::CH_ZERO + 8'd3, 1'b0, 1'b0, '0}, '{pfx_pkg::CH_NINE, 1'b0, 1'b0, '0},
            '{pfx_pkg::CH_MINUS, 1'b1, 1'b1, '{32'hFFFF_FFFA, 3'b000}},
            '{pfx_pkg::CH_NINE, 1'b0, 1'b0, '0}, '{pfx_pkg::CH_NINE, 1'b0, 1'b0, '0},
            '{pfx_pkg::CH_MUL, 1'b1, 1'b1, '{32'd81, 3'b000}},
            '{pfx_pkg::CH_NINE, 1'b0, 1'b0, '0}, '{pfx_pkg::CH_ZERO, 1'b0, 1'b0, '0},
            '{pfx_pkg::CH_DIV, 1'b1, 1'b1, '{32'd0, 3'b100}},
            '{pfx_pkg::CH_ZERO + 8'd8, 1'b0, 1'b0, '0},
            '{pfx_pkg::CH_ZERO + 8'd3, 1'b0, 1'b0, '0},
            '{pfx_pkg::CH_MOD, 1'b1, 1'b1, '{32'd2, 3'b000}},
            '{pfx_pkg::CH_PLUS, 1'b1, 1'b1, '{32'd0, 3'b001}}
        };
        foreach (table_rows[i])
            send_char(table_rows[i].ch, table_rows[i].last, table_rows[i].known,
                      table_rows[i].want);

        // Signed division: negative operands, and the most negative value over -1
        // (eight to the tenth times two wraps to the most negative value).
        send_expression("07-2/");
        send_expression("07-2%");
        send_expression("88*8*8*8*8*8*8*8*8*2*01-/");
        send_expression("88*8*8*8*8*8*8*8*8*2*01-%");

        // Overflow: more digits than the stack holds.
        for (int i = 0; i < DEPTH + 3; i++)
            send_char(pfx_pkg::CH_ZERO + 8'(i % 10), 1'b0, 1'b0, '0);
        send_char(pfx_pkg::CH_PLUS, 1'b1, 1'b0, '0);

        // Hold off until every outstanding result has arrived.
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);

        total = 0;
        while (total < 800)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
                total++;
            end
            else
            begin
                send_random_expression(sent);
                total += sent;
            end
        end

        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (error_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
